### rtl/core/cdh_pkg.sv
// Shared types and constants for the click, double-click and hold classifier.
// Holds the input and result word structs, opcode, gesture and register codes.
// Depends on nothing; every other file of the block imports it.
package cdh_pkg;

    localparam int NUM_SOURCES  = 3;
    localparam int TIME_BITS    = 32;
    localparam int BUTTON_BITS  = 8;
    localparam int SOURCE_BITS  = 2;
    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_PRESS   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [1:0] G_NONE   = 2'd0;
    localparam logic [1:0] G_CLICK  = 2'd1;
    localparam logic [1:0] G_DOUBLE = 2'd2;
    localparam logic [1:0] G_HOLD   = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_DOUBLE_CLICK = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD         = 1'd1;

    localparam logic [CFG_BITS-1:0] DEFAULT_DOUBLE_CLICK_MS = 16'd150;
    localparam logic [CFG_BITS-1:0] DEFAULT_HOLD_MS         = 16'd200;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]             op;
        logic [SOURCE_BITS-1:0] source;
        logic [7:0]             button;
    } in_word_t;

    typedef struct packed {
        logic [1:0] gesture;
        logic       last_of_item;
    } out_word_t;

endpackage

### rtl/core/click_double_hold_classifier_top.sv
// Top level of the click, double-click and hold classifier.
// Holds the timing state, the classification logic and a four-word result queue.
// Depends on cdh_pkg.

// The block takes one input word per cycle (tick, press or release) and
// classifies it in the cycle it is accepted, against the millisecond clock,
// the last press and release times and the held button of each source. Each
// word yields one result word, or two when a pending single click is reported
// first; the results go into a four-word queue that feeds the output, so an
// item is taken every cycle while two or more queue slots are free, and
// in_stall rises only while fewer than two queue slots are free. The window
// registers are to be written while no words are in flight.
module click_double_hold_classifier_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  cdh_pkg::in_word_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output cdh_pkg::out_word_t                  out_data,
    input  logic                                cfg_we,
    input  logic [cdh_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [cdh_pkg::CFG_BITS-1:0]        cfg_data
);
    import cdh_pkg::*;

    logic [CFG_BITS-1:0]    double_click_reg;
    logic [CFG_BITS-1:0]    hold_reg;

    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic [TIME_BITS-1:0]   press_time_reg, press_time_next;
    logic [TIME_BITS-1:0]   release_time_reg, release_time_next;
    logic [BUTTON_BITS-1:0] held_reg [NUM_SOURCES];
    logic [BUTTON_BITS-1:0] held_next [NUM_SOURCES];
    logic                   click_reported_reg, click_reported_next;

    out_word_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;

    logic                   in_fire;
    logic                   out_fire;
    logic [TIME_BITS-1:0]   since_release;
    logic [TIME_BITS-1:0]   since_press;
    logic                   nothing_held;
    logic                   click_fire;
    logic [1:0]             gesture;
    logic                   src_ok;
    logic [BUTTON_BITS-1:0] btn;
    logic [SOURCE_BITS-1:0] src;
    logic [QCNT_BITS-1:0]   push_count;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    assign in_stall  = (count_reg > QCNT_BITS'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = queue_reg[rd_ptr_reg];

    assign since_release = now_reg - release_time_reg;
    assign since_press   = now_reg - press_time_reg;
    assign btn           = in_data.button[BUTTON_BITS-1:0];
    assign src           = in_data.source;
    assign src_ok        = (src < SOURCE_BITS'(NUM_SOURCES));

    always_comb
    begin
        nothing_held = 1'b1;
        for (int s = 0; s < NUM_SOURCES; s++)
        begin
            if (held_reg[s] != '0)
            begin
                nothing_held = 1'b0;
            end
        end
    end

    assign click_fire = !click_reported_reg && nothing_held
                        && (since_release > TIME_BITS'(double_click_reg));

    always_comb
    begin
        now_next            = now_reg;
        press_time_next     = press_time_reg;
        release_time_next   = release_time_reg;
        held_next           = held_reg;
        click_reported_next = click_reported_reg | click_fire;
        gesture             = G_NONE;

        if (in_data.op == OP_TICK)
        begin
            now_next = now_reg + TIME_BITS'(1);
        end
        else if (in_data.op == OP_PRESS && src_ok)
        begin
            click_reported_next = 1'b0;
            for (int s = 0; s < NUM_SOURCES; s++)
            begin
                held_next[s] = '0;
            end
            if (since_release < TIME_BITS'(double_click_reg))
            begin
                click_reported_next = 1'b1;
                gesture             = G_DOUBLE;
            end
            else
            begin
                press_time_next = now_reg;
                held_next[src]  = btn;
            end
        end
        else if (in_data.op == OP_RELEASE && src_ok)
        begin
            if (held_reg[src] == btn)
            begin
                for (int s = 0; s < NUM_SOURCES; s++)
                begin
                    held_next[s] = '0;
                end
                if (since_press >= TIME_BITS'(hold_reg))
                begin
                    click_reported_next = 1'b1;
                    gesture             = G_HOLD;
                end
                else
                begin
                    release_time_next = now_reg;
                end
            end
        end
    end

    assign push_count  = in_fire ? (click_fire ? QCNT_BITS'(2) : QCNT_BITS'(1)) : '0;
    assign count_next  = count_reg + push_count - QCNT_BITS'(out_fire);
    assign wr_ptr_next = wr_ptr_reg + push_count[QPTR_BITS-1:0];
    assign rd_ptr_next = rd_ptr_reg + QPTR_BITS'(out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            double_click_reg <= DEFAULT_DOUBLE_CLICK_MS;
            hold_reg         <= DEFAULT_HOLD_MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DOUBLE_CLICK: double_click_reg <= cfg_data;
                REG_HOLD:         hold_reg         <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg            <= '0;
            press_time_reg     <= '0;
            release_time_reg   <= '0;
            click_reported_reg <= 1'b1;
            for (int s = 0; s < NUM_SOURCES; s++)
            begin
                held_reg[s] <= '0;
            end
        end
        else if (in_fire)
        begin
            now_reg            <= now_next;
            press_time_reg     <= press_time_next;
            release_time_reg   <= release_time_next;
            click_reported_reg <= click_reported_next;
            held_reg           <= held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (click_fire)
            begin
                queue_reg[wr_ptr_reg]                      <= '{gesture: G_CLICK,
                                                                last_of_item: 1'b0};
                queue_reg[wr_ptr_reg + QPTR_BITS'(1)]      <= '{gesture: gesture,
                                                                last_of_item: 1'b1};
            end
            else
            begin
                queue_reg[wr_ptr_reg] <= '{gesture: gesture, last_of_item: 1'b1};
            end
        end
    end

endmodule

### rtl/core/cdh_checker.sv
// Port-level checks for the click, double-click and hold classifier.
// Holds the checker module and the bind that attaches it to the top level.
// Depends on cdh_pkg and click_double_hold_classifier_top.
module cdh_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  cdh_pkg::out_word_t                  out_data
);
    import cdh_pkg::*;

    // A stalled result word stays on the output unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result word changed or dropped");

    // A single click is always followed by the word that closes its item.
    a_click_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.gesture == G_CLICK |-> !out_data.last_of_item)
        else $error("single click marked as last word of an item");

    // The closing word of an item is queued together with its first word.
    a_item_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last_of_item |=> out_valid)
        else $error("item split: closing word missing");

    // The input is only held off while results are waiting.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with an empty result queue");

endmodule

bind click_double_hold_classifier_top cdh_checker u_cdh_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

### test/click_double_hold_classifier_checker.sv
// Checker for the click, double-click and hold classifier: watches the input, output
// and register ports, predicts the gesture words and compares them with the block.
// Depends on cdh_pkg.
module click_double_hold_classifier_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  cdh_pkg::in_word_t                   in_data,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  cdh_pkg::out_word_t                  out_data,
    input  logic                                cfg_we,
    input  logic [cdh_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [cdh_pkg::CFG_BITS-1:0]        cfg_data,
    output int                                  gesture_errors,
    output int                                  gestures_due,
    output int                                  n_results,
    output int                                  n_click,
    output int                                  n_double,
    output int                                  n_hold
);
    import cdh_pkg::*;

    logic [TIME_BITS-1:0]   clock_ms;
    logic [TIME_BITS-1:0]   last_press_ms;
    logic [TIME_BITS-1:0]   last_release_ms;
    logic [BUTTON_BITS-1:0] held [NUM_SOURCES];
    logic                   click_done;
    logic [CFG_BITS-1:0]    window_dbl;
    logic [CFG_BITS-1:0]    window_hold;
    out_word_t              expected_gestures[$];
    int                     errs;
    int                     seen [4];

    function automatic out_word_t make_result(input logic [1:0] g, input logic last);
        out_word_t r;
        r.gesture = g;
        r.last_of_item = last;
        return r;
    endfunction

    function automatic bit all_released();
        for (int s = 0; s < NUM_SOURCES; s++)
        begin
            if (held[s] != '0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_held();
        for (int s = 0; s < NUM_SOURCES; s++)
            held[s] = '0;
    endtask

    task automatic classify_word(input in_word_t w);
        logic [1:0]           g;
        logic [TIME_BITS-1:0] since_release;
        logic [TIME_BITS-1:0] since_press;
        g = G_NONE;
        since_release = clock_ms - last_release_ms;
        since_press = clock_ms - last_press_ms;
        if (!click_done && all_released() && since_release > window_dbl)
        begin
            click_done = 1'b1;
            expected_gestures.push_back(make_result(G_CLICK, 1'b0));
        end
        if (w.op == OP_TICK)
            clock_ms = clock_ms + 1'b1;
        else if (w.op == OP_PRESS && w.source < NUM_SOURCES)
        begin
            click_done = 1'b0;
            clear_held();
            if (since_release < window_dbl)
            begin
                click_done = 1'b1;
                g = G_DOUBLE;
            end
            else
            begin
                last_press_ms = clock_ms;
                held[w.source] = w.button;
            end
        end
        else if (w.op == OP_RELEASE && w.source < NUM_SOURCES)
        begin
            if (held[w.source] == w.button)
            begin
                clear_held();
                if (since_press >= window_hold)
                begin
                    click_done = 1'b1;
                    g = G_HOLD;
                end
                else
                    last_release_ms = clock_ms;
            end
        end
        expected_gestures.push_back(make_result(g, 1'b1));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want;
        if (!rst_n)
        begin
            window_dbl = DEFAULT_DOUBLE_CLICK_MS;
            window_hold = DEFAULT_HOLD_MS;
            clock_ms = '0;
            last_press_ms = '0;
            last_release_ms = '0;
            clear_held();
            click_done = 1'b1;
            expected_gestures.delete();
            errs = 0;
            for (int k = 0; k < 4; k++)
                seen[k] = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen[out_data.gesture]++;
                if (expected_gestures.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("ERROR: unexpected word gesture=%0d last=%0d",
                                 out_data.gesture, out_data.last_of_item);
                end
                else
                begin
                    want = expected_gestures.pop_front();
                    if (out_data.gesture !== want.gesture ||
                        out_data.last_of_item !== want.last_of_item)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display("ERROR: gesture %0d last %0d expected, %0d last %0d seen",
                                     want.gesture, want.last_of_item,
                                     out_data.gesture, out_data.last_of_item);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DOUBLE_CLICK: window_dbl = cfg_data;
                    REG_HOLD:         window_hold = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                classify_word(in_data);
        end
        gesture_errors <= errs;
        gestures_due <= expected_gestures.size();
        n_results <= seen[0] + seen[1] + seen[2] + seen[3];
        n_click <= seen[G_CLICK];
        n_double <= seen[G_DOUBLE];
        n_hold <= seen[G_HOLD];
    end

endmodule

### test/click_double_hold_classifier_top_tb.sv
// Testbench top for the click, double-click and hold classifier: drives reset, the
// register port and random gesture sequences, and gives the verdict from the checker.
// Depends on cdh_pkg, click_double_hold_classifier_top and the checker module.
module click_double_hold_classifier_top_tb;
    import cdh_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [1:0] SRC_KEYBOARD = 2'd0;
    localparam logic [1:0] SRC_MOUSE    = 2'd1;
    localparam logic [1:0] SRC_JOYSTICK = 2'd2;
    localparam logic [1:0] SRC_INVALID  = 2'd3;
    localparam int         TIMEOUT      = 20_000_000;
    localparam int         LONG_HOLD    = 300;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    in_word_t                in_data;
    logic                    out_valid;
    logic                    out_stall;
    out_word_t               out_data;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    int gesture_errors;
    int gestures_due;
    int n_results;
    int n_click;
    int n_double;
    int n_hold;

    int dbl_cfg;
    int hold_cfg;
    int n_words;
    int n_items;
    int n_settings;
    int n_long_holds;
    bit tx_quiet;
    bit rx_quiet;
    bit long_hold_req;

    click_double_hold_classifier_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    click_double_hold_classifier_checker i_gesture_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .gesture_errors (gesture_errors),
        .gestures_due   (gestures_due),
        .n_results      (n_results),
        .n_click        (n_click),
        .n_double       (n_double),
        .n_hold         (n_hold)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int tick_run();
        int n;
        case ($urandom_range(0, 5))
            0:       n = dbl_cfg + $urandom_range(0, 2) - 1;
            1:       n = hold_cfg + $urandom_range(0, 2) - 1;
            2:       n = $urandom_range(0, 2 * dbl_cfg + 2);
            default: n = $urandom_range(0, 4);
        endcase
        if (n < 0)
            n = 0;
        if (n > 260)
            n = $urandom_range(0, 6);
        return n;
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        gap = pick_gap(tx_quiet);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (in_stall);
        n_words++;
        if (w.op == OP_TICK || (w.op != OP_UNUSED && w.source < NUM_SOURCES))
            n_items++;
    endtask

    task automatic put(input logic [1:0] op, input logic [1:0] src, input logic [7:0] btn);
        in_word_t w;
        w.op = op;
        w.source = src;
        w.button = btn;
        send_word(w);
    endtask

    task automatic ticks(input int n);
        repeat (n) put(OP_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(posedge clk); while (gestures_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_windows(input int dbl, input int hold);
        settle();
        write_reg(REG_DOUBLE_CLICK, CFG_BITS'(dbl));
        write_reg(REG_HOLD, CFG_BITS'(hold));
        dbl_cfg = dbl;
        hold_cfg = hold;
        n_settings++;
    endtask

    task automatic play_sequence();
        logic [1:0] src;
        logic [1:0] other;
        logic [7:0] btn;
        if ($urandom_range(0, 99) < 12)
        begin
            put(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                8'($urandom_range(0, 255)));
            return;
        end
        src = 2'($urandom_range(0, 2));
        other = (src == SRC_JOYSTICK) ? SRC_KEYBOARD : src + 1'b1;
        btn = (src == SRC_JOYSTICK) ? 8'($urandom_range(0, 255)) : 8'h01;
        if ($urandom_range(0, 19) == 0)
            btn = 8'h00;
        put(OP_PRESS, src, btn);
        ticks(tick_run());
        case ($urandom_range(0, 9))
            0: put(OP_RELEASE, src, btn ^ 8'($urandom_range(1, 255)));
            1: put(OP_PRESS, other, (other == SRC_JOYSTICK) ? 8'($urandom_range(0, 255)) : 8'h01);
            2: put(OP_UNUSED, src, btn);
            3: put(OP_PRESS, SRC_INVALID, btn);
            default: ;
        endcase
        put(OP_RELEASE, src, btn);
        ticks(tick_run());
    endtask

    task automatic run_phase(input int budget, input bit pressure);
        int start;
        bit pushed;
        start = n_items;
        pushed = 1'b0;
        while (n_items - start < budget)
        begin
            tx_quiet = ($urandom_range(0, 9) == 0);
            rx_quiet = ($urandom_range(0, 9) == 0);
            if (pressure && !pushed && n_items - start > budget / 3)
            begin
                pushed = 1'b1;
                tx_quiet = 1'b1;
                long_hold_req = 1'b1;
                while (long_hold_req)
                    ticks(1);
                ticks(30);
                tx_quiet = 1'b0;
            end
            play_sequence();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial
    begin : receiver
        int  len;
        bit  hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                n_long_holds++;
                hold = 1'b1;
                len = LONG_HOLD;
            end
            else if (rx_quiet || $urandom_range(0, 1))
            begin
                hold = 1'b0;
                len = $urandom_range(1, 12);
            end
            else
            begin
                hold = 1'b1;
                len = pick_gap(1'b0) + 1;
            end
            @(negedge clk);
            out_stall <= hold;
            repeat (len - 1) @(negedge clk);
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        dbl_cfg = int'(DEFAULT_DOUBLE_CLICK_MS);
        hold_cfg = int'(DEFAULT_HOLD_MS);
        n_words = 0;
        n_items = 0;
        n_settings = 1;
        n_long_holds = 0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        long_hold_req = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        put(OP_TICK, SRC_INVALID, 8'hFF);
        put(OP_UNUSED, SRC_KEYBOARD, 8'hFF);
        put(OP_PRESS, SRC_INVALID, 8'h01);
        put(OP_RELEASE, SRC_INVALID, 8'h01);
        put(OP_PRESS, SRC_KEYBOARD, 8'h01);
        put(OP_RELEASE, SRC_KEYBOARD, 8'h01);
        put(OP_RELEASE, SRC_JOYSTICK, 8'h00);
        set_windows(2, 3);
        ticks(3);
        put(OP_PRESS, SRC_JOYSTICK, 8'h80);
        ticks(3);
        put(OP_RELEASE, SRC_JOYSTICK, 8'h80);
        put(OP_PRESS, SRC_MOUSE, 8'h01);
        ticks(1);
        put(OP_RELEASE, SRC_MOUSE, 8'h01);
        put(OP_PRESS, SRC_MOUSE, 8'h01);
        ticks(3);
        put(OP_PRESS, SRC_KEYBOARD, 8'h00);
        ticks(3);
        put(OP_PRESS, SRC_JOYSTICK, 8'h7F);
        put(OP_PRESS, SRC_KEYBOARD, 8'h01);
        put(OP_RELEASE, SRC_JOYSTICK, 8'h7F);
        put(OP_UNUSED, SRC_INVALID, 8'h00);

        set_windows(int'(DEFAULT_DOUBLE_CLICK_MS), int'(DEFAULT_HOLD_MS));
        run_phase(420, 1'b1);
        set_windows(0, 0);
        run_phase(150, 1'b0);
        set_windows(65535, 65535);
        run_phase(100, 1'b0);
        set_windows(65535, 0);
        run_phase(80, 1'b0);
        set_windows(0, 65535);
        run_phase(80, 1'b0);
        for (int k = 0; k < 4; k++)
        begin
            set_windows($urandom_range(0, 12), $urandom_range(0, 12));
            run_phase(150, k == 2);
        end

        settle();
        repeat (8) @(posedge clk);
        $display("Covered %0d words (%0d effective) over %0d window settings, %0d long holds.",
                 n_words, n_items, n_settings, n_long_holds);
        $display("Checked %0d results: %0d single clicks, %0d double clicks, %0d holds.",
                 n_results, n_click, n_double, n_hold);
        if (gesture_errors == 0 && gestures_due == 0)
            $display("click_double_hold_classifier_top test passed");
        else
            $display("click_double_hold_classifier_top test failed");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT);
        $display("click_double_hold_classifier_top test failed");
        $finish;
    end

endmodule
